// ===== hdl/dmpg_pkg.sv =====
// Shared constants, payload types and helpers of the drum map pattern generator.
`default_nettype none

package dmpg_pkg;

    // Pattern geometry
    localparam int STEPS      = 32;
    localparam int GRID_SIDE  = 5;
    localparam int VOICES     = 3;
    localparam int NODE_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int TABLE_SIZE = NODE_COUNT * VOICES * STEPS;
    localparam int NODE_SPAN  = VOICES * STEPS;

    // Voices on the result side and voices that are blended
    localparam int OUT_VOICES   = 3;
    localparam int BLEND_VOICES = (VOICES < OUT_VOICES) ? VOICES : OUT_VOICES;

    // Widths
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int STEP_W     = $clog2(STEPS);
    localparam int IDX_W      = $clog2(GRID_SIDE);
    localparam int POS_W      = 11;
    localparam int SCALED_W   = POS_W + $clog2(GRID_SIDE);
    localparam int DENS_W     = 9;
    localparam int RND_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int FRAC_W     = 8;
    localparam int WGT_W      = 17;
    localparam int ACC_W      = 24;
    localparam int BLEND_SHIFT = 16;
    localparam int VOICE_W    = 2;
    localparam int CORNER_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int LIM_PROD_W = 36;

    // Fixed-point constants
    localparam logic [POS_W-1:0]  POS_ONE      = 11'd1024;
    localparam logic [DENS_W-1:0] Q8_ONE       = 9'd256;
    localparam logic [BYTE_W-1:0] ACCENT_LEVEL = 8'd200;
    localparam int THR_SCALE  = 254;
    localparam int REM_MUL    = 384;     // c*768/10 = c*384/5
    localparam int ADD_MUL    = 128;     // c*256/10 = c*128/5
    localparam int DIV5_MUL   = 209716;  // ceil(2^20 / 5), exact below 2^18
    localparam int DIV5_SHIFT = 20;
    localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd3;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_X_POSITION   = 3'd0;
    localparam cfg_index_t REG_Y_POSITION   = 3'd1;
    localparam cfg_index_t REG_KICK_DENSITY = 3'd2;
    localparam cfg_index_t REG_SNARE_DENSITY = 3'd3;
    localparam cfg_index_t REG_HAT_DENSITY  = 3'd4;
    localparam cfg_index_t REG_CHAOS_AMOUNT = 3'd5;

    // Input item
    typedef struct packed {
        logic                func;
        logic [11:0]         table_address;
        logic [7:0]          table_value;
        logic [RND_W-1:0]    kick_random;
        logic [RND_W-1:0]    snare_random;
        logic [RND_W-1:0]    hat_random;
    } item_t;

    // Result item
    typedef struct packed {
        logic [4:0] step_index;
        logic       kick_trigger;
        logic       snare_trigger;
        logic       hat_trigger;
        logic       kick_accent;
        logic       snare_accent;
        logic       hat_accent;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                write;
        logic                start;
        logic                issue;
        logic                load;
        logic [VOICE_W-1:0]  voice;
        logic [CORNER_W-1:0] corner;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_stall;
    } dp_status_t;

    // Node indexes and fraction of one map coordinate
    typedef struct packed {
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [FRAC_W-1:0] frac;
    } pos_split_t;

    function automatic pos_split_t split_pos(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0]    p;
        logic [SCALED_W-1:0] s;
        pos_split_t          r;
        p = (pos > POS_ONE) ? POS_ONE : pos;
        s = SCALED_W'(p) * SCALED_W'(GRID_SIDE - 1);
        r.lo   = IDX_W'(s[SCALED_W-1:10]);
        r.frac = s[9:2];
        r.hi   = (r.lo == IDX_W'(GRID_SIDE - 1)) ? r.lo : r.lo + IDX_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/drum_map_pattern_generator.sv =====
// A tick transfer makes 12 corner reads through the single table port, then drains
// the last read and loads its result, holding while the result output is stalled.
// No new item is taken until that load; a table write transfer is taken while idle
// and yields no result.
// Reset: rst_n clears the step counter and loads the register defaults; the
// pattern table holds no defined contents until written.
`default_nettype none

module drum_map_pattern_generator (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire dmpg_pkg::item_t       item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output dmpg_pkg::result_t          result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire dmpg_pkg::cfg_index_t  cfg_index,
    input  wire logic [dmpg_pkg::CFG_DATA_W-1:0] cfg_data
);

    import dmpg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence the work of each item
    dmpg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_func  (item.func),
        .item_ready (item_ready),
        .cmd        (cmd),
        .status     (status)
    );

    // Store, blend and evaluate
    dmpg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== hdl/dmpg_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module dmpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/dmpg_ctrl.sv =====
// Controller state machine: sequences table writes, corner reads and result loads.
`default_nettype none

module dmpg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    input  wire logic                item_func,
    output logic                     item_ready,
    output dmpg_pkg::dp_cmd_t        cmd,
    input  wire dmpg_pkg::dp_status_t status
);

    import dmpg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [VOICE_W-1:0]  voice_reg, voice_next;
    logic [CORNER_W-1:0] corner_reg, corner_next;
    logic                take_write;
    logic                take_tick;
    logic                last_read;

    assign item_ready = (state_reg == S_IDLE);
    assign take_write = item_ready && item_valid && (item_func == FUNC_WRITE);
    assign take_tick  = item_ready && item_valid && (item_func == FUNC_TICK);
    assign last_read  = (voice_reg == VOICE_W'(BLEND_VOICES - 1)) &&
                        (corner_reg == LAST_CORNER);

    // Next state and read counters
    always_comb
    begin
        state_next  = state_reg;
        voice_next  = voice_reg;
        corner_next = corner_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take_tick)
                begin
                    state_next  = S_READ;
                    voice_next  = '0;
                    corner_next = '0;
                end
            end
            S_READ:
            begin
                corner_next = corner_reg + CORNER_W'(1);
                if (corner_reg == LAST_CORNER)
                begin
                    voice_next = voice_reg + VOICE_W'(1);
                end
                if (last_read)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            voice_reg  <= '0;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            voice_reg  <= voice_next;
            corner_reg <= corner_next;
        end
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.write  = take_write;
        cmd.start  = take_tick;
        cmd.issue  = (state_reg == S_READ);
        cmd.load   = (state_reg == S_DONE) && !status.out_stall;
        cmd.voice  = voice_reg;
        cmd.corner = corner_reg;
    end

    // A tick starts its reads at the first corner of the first voice
    a_start_first_read: assert property (@(posedge clk) disable iff (!rst_n)
        take_tick |=> (state_reg == S_READ) && (voice_reg == '0) && (corner_reg == '0))
        else $error("tick did not start at the first corner read");

    // The drain state follows the last read
    a_drain_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> ($past(state_reg) == S_READ) && $past(last_read))
        else $error("drain entered without finishing the reads");

    // No item is taken while reads are in flight
    a_no_take_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !item_ready)
        else $error("item accepted during corner reads");

endmodule

`default_nettype wire

// ===== hdl/dmpg_datapath.sv =====
// Datapath: configuration registers, pattern memory, bilinear blend and trigger logic.
`default_nettype none

module dmpg_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dmpg_pkg::item_t       item,
    input  wire dmpg_pkg::dp_cmd_t     cmd,
    output dmpg_pkg::dp_status_t       status,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire dmpg_pkg::cfg_index_t  cfg_index,
    input  wire logic [dmpg_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output dmpg_pkg::result_t          result
);

    import dmpg_pkg::*;

    // Configuration and sequencer state
    logic [POS_W-1:0]  x_pos_reg;
    logic [POS_W-1:0]  y_pos_reg;
    logic [DENS_W-1:0] dens_reg [OUT_VOICES];
    logic [DENS_W-1:0] chaos_reg;
    logic [STEP_W-1:0] step_reg, step_next;

    // Per-tick payload
    logic [RND_W-1:0]  rnd_reg [OUT_VOICES];
    logic [BYTE_W-1:0] value_reg [OUT_VOICES];
    logic [ACC_W-1:0]  acc_reg;
    logic [WGT_W-1:0]  w_reg;
    logic [VOICE_W-1:0] rd_voice_reg;
    logic              rd_last_reg;
    logic              rd_valid_reg;
    logic [RND_W-1:0]  rem_lim_reg;
    logic [RND_W-1:0]  add_lim_reg;

    // Result register
    logic              out_valid_reg;
    result_t           out_data_reg;

    // Address and weight of the corner being issued
    pos_split_t         xs, ys;
    logic [IDX_W-1:0]   x_sel, y_sel;
    logic [ADDR_W-1:0]  node;
    logic [ADDR_W-1:0]  rd_addr;
    logic [DENS_W-1:0]  wx, wy;
    logic [2*DENS_W-1:0] w_prod;

    // Memory port
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [BYTE_W-1:0]  ram_rdata;

    // Accumulation
    logic [BYTE_W+WGT_W-1:0] cell_prod;
    logic [ACC_W:0]          acc_sum;

    // Chaos limits
    logic [DENS_W-1:0]     c_sat;
    logic [LIM_PROD_W-1:0] rem_prod, add_prod;

    // Trigger evaluation
    logic [OUT_VOICES-1:0] trig, acc_bit;
    result_t               res;

    assign cfg_ready = 1'b1;

    // Store configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pos_reg <= 11'd512;
            y_pos_reg <= 11'd512;
            for (int i = 0; i < OUT_VOICES; i++)
            begin
                dens_reg[i] <= 9'd128;
            end
            chaos_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_POSITION:    x_pos_reg   <= cfg_data;
                REG_Y_POSITION:    y_pos_reg   <= cfg_data;
                REG_KICK_DENSITY:  dens_reg[0] <= cfg_data[DENS_W-1:0];
                REG_SNARE_DENSITY: dens_reg[1] <= cfg_data[DENS_W-1:0];
                REG_HAT_DENSITY:   dens_reg[2] <= cfg_data[DENS_W-1:0];
                REG_CHAOS_AMOUNT:  chaos_reg   <= cfg_data[DENS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Form the table address and bilinear weight of one corner
    always_comb
    begin
        xs     = split_pos(x_pos_reg);
        ys     = split_pos(y_pos_reg);
        x_sel  = cmd.corner[0] ? xs.hi : xs.lo;
        y_sel  = cmd.corner[1] ? ys.hi : ys.lo;
        node   = ADDR_W'(y_sel) * ADDR_W'(GRID_SIDE) + ADDR_W'(x_sel);
        rd_addr = node * ADDR_W'(NODE_SPAN) + ADDR_W'(cmd.voice) * ADDR_W'(STEPS)
                + ADDR_W'(step_reg);
        wx     = cmd.corner[0] ? {1'b0, xs.frac} : (Q8_ONE - {1'b0, xs.frac});
        wy     = cmd.corner[1] ? {1'b0, ys.frac} : (Q8_ONE - {1'b0, ys.frac});
        w_prod = (2*DENS_W)'(wx) * (2*DENS_W)'(wy);
    end

    // Share the one memory port between writes and corner reads
    assign ram_we   = cmd.write && (int'(item.table_address) < TABLE_SIZE);
    assign ram_addr = cmd.write ? ADDR_W'(item.table_address) : rd_addr;

    dmpg_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.table_value),
        .rdata (ram_rdata)
    );

    // Track the read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            w_reg        <= WGT_W'(w_prod);
            rd_voice_reg <= cmd.voice;
            rd_last_reg  <= (cmd.corner == LAST_CORNER);
        end
    end

    // Weight each returned byte and accumulate the corners of one voice
    assign cell_prod = (BYTE_W+WGT_W)'(ram_rdata) * (BYTE_W+WGT_W)'(w_reg);
    assign acc_sum   = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(cell_prod);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= '0;
            for (int i = 0; i < OUT_VOICES; i++)
            begin
                value_reg[i] <= '0;
            end
            rnd_reg[0] <= item.kick_random;
            rnd_reg[1] <= item.snare_random;
            rnd_reg[2] <= item.hat_random;
        end
        else if (rd_valid_reg)
        begin
            if (rd_last_reg)
            begin
                acc_reg <= '0;
                for (int i = 0; i < OUT_VOICES; i++)
                begin
                    if (rd_voice_reg == VOICE_W'(i))
                    begin
                        value_reg[i] <= acc_sum[ACC_W-1:BLEND_SHIFT];
                    end
                end
            end
            else
            begin
                acc_reg <= acc_sum[ACC_W-1:0];
            end
        end
    end

    // Chaos limits: c*0.3 and c*0.1 in 16-bit scale, by reciprocal of five
    always_comb
    begin
        c_sat    = (chaos_reg > Q8_ONE) ? Q8_ONE : chaos_reg;
        rem_prod = (LIM_PROD_W'(c_sat) * LIM_PROD_W'(REM_MUL)) * LIM_PROD_W'(DIV5_MUL);
        add_prod = (LIM_PROD_W'(c_sat) * LIM_PROD_W'(ADD_MUL)) * LIM_PROD_W'(DIV5_MUL);
    end

    always_ff @(posedge clk)
    begin
        rem_lim_reg <= RND_W'(rem_prod >> DIV5_SHIFT);
        add_lim_reg <= RND_W'(add_prod >> DIV5_SHIFT);
    end

    // Threshold, chaos and accent per voice
    always_comb
    begin
        logic [DENS_W-1:0] d;
        logic [15:0]       thr_prod;
        logic              t;
        for (int v = 0; v < OUT_VOICES; v++)
        begin
            d        = (dens_reg[v] > Q8_ONE) ? Q8_ONE : dens_reg[v];
            thr_prod = 16'(Q8_ONE - d) * 16'(THR_SCALE);
            t        = value_reg[v] > thr_prod[15:8];
            if (d == '0)
            begin
                t = 1'b0;
            end
            else if (c_sat != '0)
            begin
                t = t ? (rnd_reg[v] > rem_lim_reg) : (rnd_reg[v] < add_lim_reg);
            end
            trig[v]    = t;
            acc_bit[v] = t && (value_reg[v] > ACCENT_LEVEL);
        end
        res.step_index    = 5'(step_reg);
        res.kick_trigger  = trig[0];
        res.snare_trigger = trig[1];
        res.hat_trigger   = trig[2];
        res.kick_accent   = acc_bit[0];
        res.snare_accent  = acc_bit[1];
        res.hat_accent    = acc_bit[2];
    end

    // Advance and wrap the step
    assign step_next = (step_reg == STEP_W'(STEPS - 1)) ? '0 : step_reg + STEP_W'(1);

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= step_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= res;
        end
    end

    assign status.out_stall = out_valid_reg && !result_ready;
    assign result_valid     = out_valid_reg;
    assign result           = out_data_reg;

    // The memory is never written while a read is returning
    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> !cmd.write)
        else $error("table write collided with a corner read");

    // A result is loaded only after the last corner has been accumulated
    a_load_after_blend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !rd_valid_reg && !cmd.issue)
        else $error("result loaded while blending");

    // Loading a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(out_valid_reg && !result_ready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
